// ===== rtl/srsw_pkg.sv =====
package srsw_pkg;

    localparam int WINDOW    = 4;
    localparam int SLOT_BITS = 2;
    localparam int SEQ_BITS  = 3;
    localparam int AGE_BITS  = 16;
    localparam int OFF_BITS  = 32;

    localparam logic [AGE_BITS-1:0] AGE_LIMIT = {AGE_BITS{1'b1}};

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_CHUNK   = 2'd1;
    localparam logic [1:0] REG_FSIZE   = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] ack_number;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  seq_number;
        logic [30:0] stream_offset;
        logic [9:0]  payload_length;
        logic        is_resend;
        logic        transfer_done;
        logic        last_of_run;
    } out_item_t;

    // one slot's contents, handed between cells on a slide
    typedef struct packed {
        logic                acked;
        logic                sent;
        logic [AGE_BITS-1:0] age;
    } slot_t;

    // commands from the controller to every cell
    typedef struct packed {
        logic                 clear;
        logic                 age;
        logic                 shift;
        logic [SLOT_BITS:0]   shift_by;
        logic                 mark_ack;
        logic [SLOT_BITS-1:0] ack_slot;
        logic                 mark_sent;
        logic [SLOT_BITS-1:0] sent_slot;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STATUS
    } state_t;

endpackage

// ===== rtl/srsw_cell.sv =====
module srsw_cell
    import srsw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SLOT_BITS-1:0] index,
    input  cell_cmd_t            cmd,
    input  slot_t                from_up [WINDOW],
    output slot_t                slot
);

    slot_t slot_reg;
    slot_t slot_next;
    logic [SLOT_BITS:0] src;

    assign src = {1'b0, index} + cmd.shift_by;

    // update one slot: clear, age, mark, or take a later slot's contents on a slide
    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.clear)
        begin
            slot_next = '0;
        end
        else if (cmd.shift)
        begin
            if (src < (SLOT_BITS+1)'(WINDOW))
                slot_next = from_up[src[SLOT_BITS-1:0]];
            else
                slot_next = '0;
        end
        else
        begin
            if (cmd.age && slot_reg.sent && !slot_reg.acked && slot_reg.age != AGE_LIMIT)
                slot_next.age = slot_reg.age + 1'b1;
            if (cmd.mark_ack && cmd.ack_slot == index)
                slot_next.acked = 1'b1;
            if (cmd.mark_sent && cmd.sent_slot == index)
            begin
                slot_next.sent = 1'b1;
                slot_next.age  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ===== rtl/selective_repeat_sender_window.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------
// input    | start, busy        | in_item (operation, ack_number)
// result   | result_valid       | result (one cycle, no stall)
// config   | cfg_we, cfg_index  | cfg_data (31 bits)
// A tick ages the slots, scans up to 4 of them, then gives a status result;
// ack, start, others and ticks once finished go straight to status. The scan
// walks the slot cells one per cycle through a single offset multiply-add.
// Reset clears the window and loads register defaults. Results cannot be
// stalled; busy is high from acceptance until the status transaction.
module selective_repeat_sender_window
    import srsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    in_item,
    output logic        result_valid,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    state_t state_reg, state_next;
    logic [15:0] timeout_reg;
    logic [9:0]  chunk_reg;
    logic [30:0] fsize_reg;
    logic [SEQ_BITS-1:0]  base_reg, base_next;
    logic [OFF_BITS-1:0]  woff_reg, woff_next;
    logic end_reg, end_next;
    logic [SLOT_BITS-1:0] wait_reg, wait_next;
    logic fin_reg, fin_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic valid_next;
    out_item_t res_next;
    out_item_t res_reg;
    logic      valid_reg;

    cell_cmd_t cmd;
    slot_t     slots [WINDOW];

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++)
        begin : g_cell
            srsw_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .index   (SLOT_BITS'(g)),
                .cmd     (cmd),
                .from_up (slots),
                .slot    (slots[g])
            );
        end
    endgenerate

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd50;
            chunk_reg   <= 10'd1008;
            fsize_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                REG_CHUNK:   chunk_reg   <= cfg_data[9:0];
                REG_FSIZE:   fsize_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // scan arithmetic for the current slot
    slot_t cur;
    logic [33:0] offset;
    logic [33:0] remain;
    logic        need;
    logic [SEQ_BITS:0] ack_span;
    logic [SLOT_BITS:0] lead;
    logic all_ok;

    assign cur      = slots[idx_reg];
    assign offset   = {2'b0, woff_reg} + 34'(12'(chunk_reg) * 12'(idx_reg));
    assign remain   = {3'b0, fsize_reg} - offset;
    assign need     = !cur.sent || (!cur.acked && cur.age > timeout_reg);
    assign ack_span = {1'b0, in_item.ack_number - base_reg};

    // leading acked count and done check after marking the ack
    always_comb
    begin
        logic [WINDOW-1:0] a;
        for (int i = 0; i < WINDOW; i++)
            a[i] = slots[i].acked || (SLOT_BITS'(i) == ack_span[SLOT_BITS-1:0]);
        lead = (SLOT_BITS+1)'(WINDOW);
        for (int i = WINDOW-1; i >= 0; i--)
            if (!a[i])
                lead = (SLOT_BITS+1)'(i);
        all_ok = 1'b1;
        for (int i = 0; i < WINDOW; i++)
            if (SLOT_BITS'(i) < wait_reg && !a[i])
                all_ok = 1'b0;
    end

    // sequence through age, scan and status
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        woff_next  = woff_reg;
        end_next   = end_reg;
        wait_next  = wait_reg;
        fin_next   = fin_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        valid_next = 1'b0;
        res_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_STATUS;
                    case (in_item.operation)
                        OP_START:
                        begin
                            cmd.clear = 1'b1;
                            base_next = '0;
                            woff_next = '0;
                            end_next  = 1'b0;
                            wait_next = '0;
                            fin_next  = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (!fin_reg)
                            begin
                                cmd.age    = 1'b1;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ACK:
                        begin
                            if (!fin_reg && ack_span < (SEQ_BITS+1)'(WINDOW))
                            begin
                                if (end_reg)
                                begin
                                    cmd.mark_ack = 1'b1;
                                    cmd.ack_slot = ack_span[SLOT_BITS-1:0];
                                    if (all_ok)
                                        fin_next = 1'b1;
                                end
                                else if (lead == '0)
                                begin
                                    cmd.mark_ack = 1'b1;
                                    cmd.ack_slot = ack_span[SLOT_BITS-1:0];
                                end
                                else
                                begin
                                    // slide; the acked slot is always among those dropped
                                    cmd.shift    = 1'b1;
                                    cmd.shift_by = lead;
                                    base_next = base_reg + SEQ_BITS'(lead);
                                    woff_next = woff_reg
                                        + OFF_BITS'(13'(chunk_reg) * 13'(lead));
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (need)
                begin
                    if (offset >= {3'b0, fsize_reg})
                    begin
                        if (!end_reg)
                            wait_next = idx_reg;
                        end_next   = 1'b1;
                        state_next = ST_STATUS;
                    end
                    else
                    begin
                        valid_next              = 1'b1;
                        res_next.seq_number     = base_reg + SEQ_BITS'(idx_reg);
                        res_next.stream_offset  = offset[30:0];
                        res_next.payload_length = (remain < 34'(chunk_reg))
                                                  ? remain[9:0] : chunk_reg;
                        res_next.is_resend      = cur.sent;
                        cmd.mark_sent           = 1'b1;
                        cmd.sent_slot           = idx_reg;
                    end
                end
                if (state_next == ST_SCAN)
                begin
                    if (idx_reg == SLOT_BITS'(WINDOW-1))
                        state_next = ST_STATUS;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_STATUS:
            begin
                valid_next             = 1'b1;
                res_next.kind          = 1'b1;
                res_next.transfer_done = fin_reg;
                res_next.last_of_run   = 1'b1;
                state_next             = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // controller state and window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            woff_reg  <= '0;
            end_reg   <= 1'b0;
            wait_reg  <= '0;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            woff_reg  <= woff_next;
            end_reg   <= end_next;
            wait_reg  <= wait_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule
